// ===== hdl/resonator_bank_band_meter_defines.svh =====
// ----------------------------------------------------------------------------
// Resonator bank band meter assertion macros
// Concurrent assertion wrappers clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef RESONATOR_BANK_BAND_METER_DEFINES_SVH
`define RESONATOR_BANK_BAND_METER_DEFINES_SVH

`ifndef ASSERT_OFF
`define RBBM_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define RBBM_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define RBBM_ASSERT(name, prop, msg)
`define RBBM_ASSERT_IMP(name, ante, cons, msg)
`endif

`endif

// ===== hdl/rbbm_pkg.sv =====
// ----------------------------------------------------------------------------
// rbbm_pkg
// Shared constants, configuration struct and log2 table for the band meter.
// ----------------------------------------------------------------------------
package rbbm_pkg;

	localparam int NUM_BANDS       = 32;
	localparam int LOG_TABLE_DEPTH = 1024;
	localparam int BAND_W          = $clog2(NUM_BANDS);
	localparam int LOG_IDX_W       = $clog2(LOG_TABLE_DEPTH);
	localparam int DATA_W          = 24;
	localparam int SAMPLE_W        = 16;
	localparam int SEL_W           = 5;
	localparam int PADDR_W         = 3;
	localparam int PDATA_W         = 32;

	localparam logic [DATA_W-1:0] DECAY_RST = 24'd16750866;
	localparam logic [DATA_W-1:0] FB2_RST   = 24'hE05022;   // -2076638
	localparam logic [DATA_W-1:0] GATE_MIN  = 24'd1049;     // 0.001
	localparam logic [DATA_W-1:0] ENV_FLOOR = 24'd11;       // 1e-5
	localparam logic [31:0]       LOG_OFFSET = 32'd2123366;  // 2.025
	localparam logic [20:0]       LOG_SCALE  = 21'd1810970;
	localparam logic [24:0]       BAR_OFFSET = 25'd1843427;
	localparam logic [27:0]       DIV5_MUL   = 28'd214748365; // ceil(2^30/5)
	localparam logic [DATA_W-1:0] MAX24U     = 24'hFFFFFF;

	// register index, taken from paddr[2]
	localparam logic REG_DECAY = 1'b0;
	localparam logic REG_FB2   = 1'b1;

	typedef struct packed {
		logic        [DATA_W-1:0] decay;
		logic signed [DATA_W-1:0] fb2;
	} cfg_t;

	typedef logic [DATA_W-1:0] log_rom_t [LOG_TABLE_DEPTH];

	// T[k] = log2(1 + (2k+1)/(2*DEPTH)) in Q.24, by repeated squaring
	function automatic log_rom_t build_log_rom();
		log_rom_t    rom;
		logic [63:0] m;
		logic [23:0] r;
		for (int k = 0; k < LOG_TABLE_DEPTH; k++) begin
			m = (64'd1 << 30) + ((64'(2 * k + 1) << 30) >> (LOG_IDX_W + 1));
			r = '0;
			for (int i = 0; i < 24; i++) begin
				m = (m * m) >> 30;
				r = r << 1;
				if (m >= (64'd1 << 31)) begin
					m = m >> 1;
					r[0] = 1'b1;
				end
			end
			rom[k] = r;
		end
		return rom;
	endfunction

	localparam log_rom_t LOG_ROM = build_log_rom();

endpackage

// ===== hdl/rbbm_in_if.sv =====
// ----------------------------------------------------------------------------
// rbbm_in_if
// Input channel: audio sample or band coefficient load.
// ----------------------------------------------------------------------------
interface rbbm_in_if;
	logic                                       valid;
	logic                                       ready;
	logic                                       action;
	logic signed [rbbm_pkg::SAMPLE_W-1:0]       sample;
	logic        [rbbm_pkg::SEL_W-1:0]          band_select;
	logic signed [rbbm_pkg::DATA_W-1:0]         input_gain;
	logic signed [rbbm_pkg::DATA_W-1:0]         first_feedback;

	modport source (output valid, action, sample, band_select, input_gain, first_feedback,
		input ready);
	modport sink (input valid, action, sample, band_select, input_gain, first_feedback,
		output ready);
endinterface

// ===== hdl/rbbm_out_if.sv =====
// ----------------------------------------------------------------------------
// rbbm_out_if
// Result channel: one transaction per band per sample.
// ----------------------------------------------------------------------------
interface rbbm_out_if;
	logic                              valid;
	logic                              ready;
	logic [rbbm_pkg::SEL_W-1:0]        band;
	logic [rbbm_pkg::DATA_W-1:0]       envelope;
	logic [rbbm_pkg::DATA_W-1:0]       bar;
	logic                              last;

	modport source (output valid, band, envelope, bar, last, input ready);
	modport sink (input valid, band, envelope, bar, last, output ready);
endinterface

// ===== hdl/resonator_bank_band_meter.sv =====
// A sample transaction starts the band sequence and results follow band by band; no new
// sample or coefficient load is accepted until the last band is done. Each band runs a
// 12-step sequence over one multiplier per step and state RAMs with one read port.
// Loads go straight to the coefficient RAM. Output stalls extend the band in progress.
// Reset: control clears, envelope and bar state read as zero; coefficients are
// undefined until loaded.
// ----------------------------------------------------------------------------
// resonator_bank_band_meter
// Two-pole resonator filter bank with per-band peak envelope and log bar meter.
// ----------------------------------------------------------------------------
module resonator_bank_band_meter (
	input  logic                          clk,
	input  logic                          arst_n,
	rbbm_in_if.sink                       audio,
	rbbm_out_if.source                    result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rbbm_pkg::PADDR_W-1:0]  paddr,
	input  logic [rbbm_pkg::PDATA_W-1:0]  pwdata,
	output logic [rbbm_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);

	rbbm_pkg::cfg_t cfg;

	rbbm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rbbm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.audio  (audio),
		.result (result)
	);

endmodule

// ===== hdl/rbbm_ram.sv =====
// ----------------------------------------------------------------------------
// rbbm_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module rbbm_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/rbbm_regs.sv =====
// ----------------------------------------------------------------------------
// rbbm_regs
// APB configuration registers: envelope decay and shared second feedback.
// ----------------------------------------------------------------------------
module rbbm_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rbbm_pkg::PADDR_W-1:0]  paddr,
	input  logic [rbbm_pkg::PDATA_W-1:0]  pwdata,
	output logic [rbbm_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output rbbm_pkg::cfg_t                cfg
);

	rbbm_pkg::cfg_t cfg_q;
	logic           wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.decay <= rbbm_pkg::DECAY_RST;
			cfg_q.fb2   <= rbbm_pkg::FB2_RST;
		end else if (wr_en) begin
			case (paddr[2])
				rbbm_pkg::REG_DECAY: cfg_q.decay <= pwdata[rbbm_pkg::DATA_W-1:0];
				rbbm_pkg::REG_FB2:   cfg_q.fb2   <= pwdata[rbbm_pkg::DATA_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			rbbm_pkg::REG_DECAY: prdata = rbbm_pkg::PDATA_W'(cfg_q.decay);
			rbbm_pkg::REG_FB2:   prdata = rbbm_pkg::PDATA_W'(cfg_q.fb2);
			default:             prdata = '0;
		endcase
	end

endmodule

// ===== hdl/rbbm_core.sv =====
// ----------------------------------------------------------------------------
// rbbm_core
// Band sequencer: reads each band's coefficients and state from RAM, runs the
// resonator, envelope and log bar steps on shared units, writes back.
// ----------------------------------------------------------------------------
`include "resonator_bank_band_meter_defines.svh"

module rbbm_core (
	input  logic              clk,
	input  logic              arst_n,
	input  rbbm_pkg::cfg_t    cfg,
	rbbm_in_if.sink           audio,
	rbbm_out_if.source        result
);

	localparam int NB    = rbbm_pkg::NUM_BANDS;
	localparam int BW    = rbbm_pkg::BAND_W;
	localparam int DW    = rbbm_pkg::DATA_W;
	localparam int C_W   = 4 * DW;   // {gain, fb1, d1, d2}
	localparam int S_W   = 2 * DW;   // {env, bar}
	localparam int ACC_W = 51;
	localparam int U_W   = 32;
	localparam int MB_W  = BW + 2;
	localparam int IW    = rbbm_pkg::LOG_IDX_W;
	localparam logic [BW-1:0] LAST_BAND = BW'(NB - 1);
	localparam logic [rbbm_pkg::SEL_W-1:0] LAST_OUT = rbbm_pkg::SEL_W'(NB - 1);
	localparam logic [4:0] P_MIN = 5'd21;

	typedef enum logic [3:0] {
		S_IDLE, S_PRIME, S_MAC0, S_MAC1, S_MAC2, S_ENV, S_ENV2, S_UMUL,
		S_NORM, S_ROM, S_YMUL, S_SUM, S_DIV, S_BAR
	} state_t;

	state_t         state_q;
	logic [BW-1:0]  band_q;
	logic [BW-1:0]  rd_addr_q;
	logic [NB-1:0]  valid_q;
	logic           rd_valid_s1;
	logic           out_valid_q;
	logic [rbbm_pkg::SEL_W-1:0] out_band_q;
	logic [DW-1:0]  out_env_q;
	logic [DW-1:0]  out_bar_q;
	logic           out_last_q;

	// datapath registers
	logic signed [rbbm_pkg::SAMPLE_W-1:0] x_q;
	logic [C_W-1:0]           cur_c_q;
	logic [S_W-1:0]           cur_s_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [DW-1:0]     o_q;
	logic [2*DW-1:0]          dec_q;
	logic [DW-1:0]            env_q;
	logic [DW-1:0]            left_q;
	logic [U_W-1:0]           u_q;
	logic [4:0]               p_q;
	logic [IW-1:0]            idx_q;
	logic [DW-1:0]            rom_q;
	logic [48:0]              yprod_q;
	logic [27:0]              s_q;
	logic [25:0]              m_q;

	// memories
	logic           c_we, s_we;
	logic [BW-1:0]  c_waddr;
	logic [C_W-1:0] c_wdata, c_rdata;
	logic [S_W-1:0] s_wdata, s_rdata, st_rd;

	logic in_fire, sel_ok, adv_bar;

	assign in_fire = audio.valid && audio.ready;
	assign sel_ok  = 32'(audio.band_select) < 32'(NB);
	assign adv_bar = (state_q == S_BAR) && (!out_valid_q || result.ready);
	assign audio.ready = (state_q == S_IDLE);

	assign result.valid    = out_valid_q;
	assign result.band     = out_band_q;
	assign result.envelope = out_env_q;
	assign result.bar      = out_bar_q;
	assign result.last     = out_last_q;

	// unwritten state entries read as zero
	assign st_rd = rd_valid_s1 ? s_rdata : '0;

	// ---------------- arithmetic ----------------
	logic signed [39:0]      p_gx;
	logic signed [2*DW-1:0]  p_fd, p_sd;
	logic signed [ACC_W-1:0] acc_rnd;
	logic signed [29:0]      acc_sh;
	logic signed [DW-1:0]    o_sat;
	logic [DW-1:0]           g_c, dec_c, env_new;
	logic [MB_W-1:0]         mul_b;
	logic [U_W-1:0]          u_prod;
	logic [4:0]              p_c;
	logic [U_W-1:0]          norm_c;
	logic [27:0]             lg_c;
	logic [25:0]             yr_c;
	logic [24:0]             y_c;
	logic [DW-1:0]           right_c;
	logic [57:0]             dprod;
	logic [27:0]             bsum;
	logic [25:0]             bq;
	logic [DW-1:0]           bar_c;

	assign p_gx = 40'($signed(c_rdata[4*DW-1:3*DW])) * 40'(x_q);
	assign p_fd = (2*DW)'($signed(cur_c_q[3*DW-1:2*DW])) * (2*DW)'($signed(cur_c_q[2*DW-1:DW]));
	assign p_sd = (2*DW)'(cfg.fb2) * (2*DW)'($signed(cur_c_q[DW-1:0]));

	assign acc_rnd = acc_q + ACC_W'(1048576);
	assign acc_sh  = acc_rnd[ACC_W-1:21];

	always_comb begin
		if (acc_sh > 30'sd8388607) begin
			o_sat = 24'sh7FFFFF;
		end else if (acc_sh < -30'sd8388608) begin
			o_sat = 24'sh800000;
		end else begin
			o_sat = acc_sh[DW-1:0];
		end
	end

	// gate: negative or below 0.001 counts as zero
	assign g_c   = (o_q < $signed({1'b0, rbbm_pkg::GATE_MIN})) ? '0 : o_q;
	assign dec_c = dec_q[2*DW-1:DW];
	assign env_new = (g_c > cur_s_q[S_W-1:DW]) ? g_c :
		((dec_c < rbbm_pkg::ENV_FLOOR) ? '0 : dec_c);

	assign mul_b  = MB_W'({band_q, 1'b0}) + MB_W'(2);
	assign u_prod = U_W'(env_q) * U_W'(mul_b);

	always_comb begin
		p_c = P_MIN;
		for (int i = 21; i < U_W; i++) begin
			if (u_q[i]) begin
				p_c = 5'(i);
			end
		end
	end

	assign norm_c = u_q << (5'(U_W - 1) - p_c);
	assign lg_c   = {4'(p_q - 5'd20), rom_q};

	assign yr_c = 26'((yprod_q + 49'd8388608) >> 24);
	assign y_c  = (yr_c > 26'(rbbm_pkg::BAR_OFFSET)) ?
		25'(yr_c - 26'(rbbm_pkg::BAR_OFFSET)) : '0;
	assign right_c = (band_q == LAST_BAND) ? '0 : st_rd[S_W-1:DW];

	assign dprod = 58'(s_q) * 58'(rbbm_pkg::DIV5_MUL);

	assign bsum = 28'(cur_s_q[DW-1:0]) + 28'({cur_s_q[DW-1:0], 1'b0}) + 28'(m_q) + 28'd2;
	assign bq   = bsum[27:2];
	assign bar_c = (env_q == '0) ? '0 :
		((bq > 26'(rbbm_pkg::MAX24U)) ? rbbm_pkg::MAX24U : bq[DW-1:0]);

	// ---------------- memory ports ----------------
	assign c_we    = (in_fire && audio.action && sel_ok) || adv_bar;
	assign c_waddr = (state_q == S_BAR) ? band_q : BW'(audio.band_select);
	assign c_wdata = (state_q == S_BAR) ?
		{cur_c_q[C_W-1:2*DW], o_q, cur_c_q[2*DW-1:DW]} :
		{audio.input_gain, audio.first_feedback, {(2*DW){1'b0}}};
	assign s_we    = adv_bar;
	assign s_wdata = {env_q, bar_c};

	rbbm_ram #(.WIDTH(C_W), .DEPTH(NB)) u_coef_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.raddr (rd_addr_q),
		.rdata (c_rdata)
	);

	rbbm_ram #(.WIDTH(S_W), .DEPTH(NB)) u_state_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (band_q),
		.wdata (s_wdata),
		.raddr (rd_addr_q),
		.rdata (s_rdata)
	);

	// ---------------- control ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			band_q      <= '0;
			rd_addr_q   <= '0;
			valid_q     <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			out_band_q  <= '0;
			out_env_q   <= '0;
			out_bar_q   <= '0;
			out_last_q  <= 1'b0;
		end else begin
			rd_valid_s1 <= valid_q[rd_addr_q];
			if (result.ready && !adv_bar) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire && !audio.action) begin
						rd_addr_q <= '0;
						state_q   <= S_PRIME;
					end
				end
				S_PRIME: state_q <= S_MAC0;
				S_MAC0: begin
					// fetch the next band now; its old envelope is the right neighbor
					rd_addr_q <= (band_q == LAST_BAND) ? band_q : band_q + 1'b1;
					state_q   <= S_MAC1;
				end
				S_MAC1: state_q <= S_MAC2;
				S_MAC2: state_q <= S_ENV;
				S_ENV:  state_q <= S_ENV2;
				S_ENV2: state_q <= S_UMUL;
				S_UMUL: state_q <= S_NORM;
				S_NORM: state_q <= S_ROM;
				S_ROM:  state_q <= S_YMUL;
				S_YMUL: state_q <= S_SUM;
				S_SUM:  state_q <= S_DIV;
				S_DIV:  state_q <= S_BAR;
				S_BAR: begin
					if (adv_bar) begin
						valid_q[band_q] <= 1'b1;
						out_valid_q <= 1'b1;
						out_band_q  <= rbbm_pkg::SEL_W'(band_q);
						out_env_q   <= env_q;
						out_bar_q   <= bar_c;
						out_last_q  <= (band_q == LAST_BAND);
						if (band_q == LAST_BAND) begin
							band_q  <= '0;
							state_q <= S_IDLE;
						end else begin
							band_q  <= band_q + 1'b1;
							state_q <= S_MAC0;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ---------------- datapath ----------------
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					x_q <= audio.sample;
				end
			end
			S_PRIME: left_q <= '0;
			S_MAC0: begin
				cur_c_q <= c_rdata;
				cur_s_q <= st_rd;
				acc_q   <= ACC_W'(p_gx) <<< 5;
			end
			S_MAC1: acc_q <= acc_q + ACC_W'(p_fd);
			S_MAC2: acc_q <= acc_q + ACC_W'(p_sd);
			S_ENV: begin
				o_q   <= o_sat;
				dec_q <= (2*DW)'(cur_s_q[S_W-1:DW]) * (2*DW)'(cfg.decay);
			end
			S_ENV2: env_q <= env_new;
			S_UMUL: u_q <= u_prod + rbbm_pkg::LOG_OFFSET;
			S_NORM: begin
				p_q   <= p_c;
				idx_q <= norm_c[U_W-2 -: IW];
			end
			S_ROM:  rom_q <= rbbm_pkg::LOG_ROM[idx_q];
			S_YMUL: yprod_q <= 49'(lg_c) * 49'(rbbm_pkg::LOG_SCALE);
			S_SUM:  s_q <= 28'(y_c) + 28'({y_c, 1'b0}) + 28'(left_q) + 28'(right_c) + 28'd2;
			S_DIV:  m_q <= dprod[55:30];
			S_BAR: begin
				if (adv_bar) begin
					left_q <= env_q;
				end
			end
			default: ;
		endcase
	end

	`RBBM_ASSERT_IMP(a_last_band, out_valid_q && out_last_q, out_band_q == LAST_OUT, "last flag on wrong band")
	`RBBM_ASSERT_IMP(a_accept_at_start, in_fire, band_q == '0 && !(state_q == S_BAR), "input accepted mid-sample")
	`RBBM_ASSERT_IMP(a_norm_range, state_q == S_ROM, p_q >= P_MIN, "log exponent below offset range")
	`RBBM_ASSERT_IMP(a_write_on_result, s_we, !out_valid_q || result.ready, "state written while result blocked")

endmodule

// ===== tb/resonator_bank_band_meter_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resonator_bank_band_meter_checker
// Watches the sample, result and register ports of the band meter, predicts
// every band reading in order and compares it field by field.
// ----------------------------------------------------------------------------
module resonator_bank_band_meter_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	rbbm_in_if                            audio,
	rbbm_out_if                           result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rbbm_pkg::PADDR_W-1:0]  paddr,
	input  logic [rbbm_pkg::PDATA_W-1:0]  pwdata,
	input  logic                          pready,
	output int                            errors,
	output int                            pending,
	output int                            readings
);

	typedef struct {
		logic [rbbm_pkg::SEL_W-1:0]  band;
		logic [rbbm_pkg::DATA_W-1:0] envelope;
		logic [rbbm_pkg::DATA_W-1:0] bar;
		logic                        last;
	} band_reading_t;

	band_reading_t readings_due[$];

	longint unsigned log2_q24[rbbm_pkg::LOG_TABLE_DEPTH];
	longint unsigned decay;
	longint          fb2;
	longint          d1[rbbm_pkg::NUM_BANDS];
	longint          d2[rbbm_pkg::NUM_BANDS];
	longint unsigned env_mem[rbbm_pkg::NUM_BANDS];
	longint unsigned bar_mem[rbbm_pkg::NUM_BANDS];
	longint          gain_mem[rbbm_pkg::NUM_BANDS];
	longint          fb1_mem[rbbm_pkg::NUM_BANDS];

	initial begin
		longint unsigned m;
		longint unsigned r;
		for (int k = 0; k < rbbm_pkg::LOG_TABLE_DEPTH; k++) begin
			m = (64'd1 << 30) + ((64'(2 * k + 1) << 30) / (2 * rbbm_pkg::LOG_TABLE_DEPTH));
			r = 0;
			for (int i = 0; i < 24; i++) begin
				m = (m * m) >> 30;
				r = r << 1;
				if (m >= (64'd1 << 31)) begin
					m = m >> 1;
					r = r | 1;
				end
			end
			log2_q24[k] = r;
		end
	end

	function automatic longint unsigned log_bar(longint unsigned env, int b);
		longint unsigned u;
		longint unsigned idx;
		longint unsigned lg;
		longint unsigned y;
		int p;
		u = env * 64'(2 * b + 2) + 64'(rbbm_pkg::LOG_OFFSET);
		p = 0;
		while (p < 63 && (u >> (p + 1)) != 0)
			p++;
		idx = ((u - (64'd1 << p)) * rbbm_pkg::LOG_TABLE_DEPTH) >> p;
		if (idx >= rbbm_pkg::LOG_TABLE_DEPTH)
			idx = rbbm_pkg::LOG_TABLE_DEPTH - 1;
		lg = (longint'(p - 20) << 24) + log2_q24[idx];
		y = (lg * 64'(rbbm_pkg::LOG_SCALE) + (64'd1 << 23)) >> 24;
		return (y > 64'(rbbm_pkg::BAR_OFFSET)) ? y - 64'(rbbm_pkg::BAR_OFFSET) : 0;
	endfunction

	task automatic run_bank(input longint x);
		longint          acc;
		longint          o;
		longint unsigned g;
		longint unsigned env;
		longint unsigned left;
		longint unsigned right;
		longint unsigned mix;
		longint unsigned bv;
		band_reading_t   rd;
		for (int b = 0; b < rbbm_pkg::NUM_BANDS; b++) begin
			acc = gain_mem[b] * x * 32 + fb1_mem[b] * d1[b] + fb2 * d2[b];
			o = (acc + (64'sd1 <<< 20)) >>> 21;
			if (o > 8388607) o = 8388607;
			if (o < -8388608) o = -8388608;
			d2[b] = d1[b];
			d1[b] = o;
			g = (o < longint'(rbbm_pkg::GATE_MIN)) ? 0 : o;
			env = env_mem[b];
			if (g > env) begin
				env = g;
			end else begin
				env = (env * decay) >> 24;
				if (env < 64'(rbbm_pkg::ENV_FLOOR)) env = 0;
			end
			env_mem[b] = env;
			if (env > 0) begin
				// left neighbor is already updated, right one is from the last sample
				left  = (b == 0) ? 0 : env_mem[b-1];
				right = (b == rbbm_pkg::NUM_BANDS - 1) ? 0 : env_mem[b+1];
				mix = (3 * log_bar(env, b) + left + right + 2) / 5;
				bv = (3 * bar_mem[b] + mix + 2) >> 2;
				if (bv > 64'(rbbm_pkg::MAX24U)) bv = 64'(rbbm_pkg::MAX24U);
			end else begin
				bv = 0;
			end
			bar_mem[b] = bv;
			rd.band     = b[rbbm_pkg::SEL_W-1:0];
			rd.envelope = env[rbbm_pkg::DATA_W-1:0];
			rd.bar      = bv[rbbm_pkg::DATA_W-1:0];
			rd.last     = (b == rbbm_pkg::NUM_BANDS - 1);
			readings_due.push_back(rd);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		band_reading_t e;
		if (!arst_n) begin
			decay = 64'(rbbm_pkg::DECAY_RST);
			fb2   = longint'($signed(rbbm_pkg::FB2_RST));
			for (int b = 0; b < rbbm_pkg::NUM_BANDS; b++) begin
				d1[b] = 0;
				d2[b] = 0;
				env_mem[b] = 0;
				bar_mem[b] = 0;
				gain_mem[b] = 0;
				fb1_mem[b] = 0;
			end
			readings_due.delete();
			errors <= 0;
			readings <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == rbbm_pkg::REG_DECAY)
					decay = 64'(pwdata[rbbm_pkg::DATA_W-1:0]);
				else
					fb2 = longint'($signed(pwdata[rbbm_pkg::DATA_W-1:0]));
			end
			if (audio.valid && audio.ready) begin
				if (audio.action) begin
					if (audio.band_select < rbbm_pkg::NUM_BANDS) begin
						gain_mem[audio.band_select] = longint'(audio.input_gain);
						fb1_mem[audio.band_select]  = longint'(audio.first_feedback);
						d1[audio.band_select] = 0;
						d2[audio.band_select] = 0;
					end
				end else begin
					run_bank(longint'(audio.sample));
				end
			end
			if (result.valid && result.ready) begin
				readings <= readings + 1;
				if (readings_due.size() == 0) begin
					$display("%0t: unexpected reading band=%0d env=%h bar=%h last=%b",
						$time, result.band, result.envelope, result.bar, result.last);
					errors <= errors + 1;
				end else begin
					e = readings_due.pop_front();
					if (e.band !== result.band || e.envelope !== result.envelope ||
						e.bar !== result.bar || e.last !== result.last) begin
						$display("%0t: mismatch expected band=%0d env=%h bar=%h last=%b",
							$time, e.band, e.envelope, e.bar, e.last);
						$display("%0t:          actual   band=%0d env=%h bar=%h last=%b",
							$time, result.band, result.envelope, result.bar, result.last);
						errors <= errors + 1;
					end
				end
			end
		end
		pending <= readings_due.size();
	end

endmodule

// ===== tb/resonator_bank_band_meter_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resonator_bank_band_meter_test
// Loads band coefficients, runs directed and random audio through the meter
// under several decay and feedback settings and random stalls on both sides.
// ----------------------------------------------------------------------------
module resonator_bank_band_meter_test;

	logic                          clk;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [rbbm_pkg::PADDR_W-1:0]  paddr;
	logic [rbbm_pkg::PDATA_W-1:0]  pwdata;
	logic [rbbm_pkg::PDATA_W-1:0]  prdata;
	logic                          pready;
	int                            errors;
	int                            pending;
	int                            readings;
	int                            send_idle_pct;
	int                            recv_idle_pct;
	int                            hold_left;
	bit                            hold_req;
	bit                            hold_done;
	int                            samples_sent;
	int                            loads_sent;

	rbbm_in_if  audio ();
	rbbm_out_if result ();

	resonator_bank_band_meter DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.audio   (audio),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	resonator_bank_band_meter_checker checker_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.audio    (audio),
		.result   (result),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.pready   (pready),
		.errors   (errors),
		.pending  (pending),
		.readings (readings)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("** resonator_bank_band_meter: FAILED **");
		$finish;
	end

	// result side: random stalls plus one long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
			hold_left = 0;
			hold_done = 0;
		end else if (hold_req && !hold_done) begin
			hold_left = 3000;
			hold_done = 1;
			result.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			result.ready <= 1'b0;
		end else begin
			result.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send(input logic act, input logic signed [rbbm_pkg::SAMPLE_W-1:0] smp,
		input logic [rbbm_pkg::SEL_W-1:0] sel, input logic signed [rbbm_pkg::DATA_W-1:0] gain,
		input logic signed [rbbm_pkg::DATA_W-1:0] fb1);
		while ($urandom_range(99) < send_idle_pct) begin
			audio.valid <= 1'b0;
			@(posedge clk);
		end
		audio.action         <= act;
		audio.sample         <= smp;
		audio.band_select    <= sel;
		audio.input_gain     <= gain;
		audio.first_feedback <= fb1;
		audio.valid          <= 1'b1;
		do @(posedge clk); while (!audio.ready);
		if (act) loads_sent++;
		else samples_sent++;
	endtask

	task automatic load_band(input logic [rbbm_pkg::SEL_W-1:0] sel, input bit wild);
		logic signed [rbbm_pkg::DATA_W-1:0] gain;
		logic signed [rbbm_pkg::DATA_W-1:0] fb1;
		if (wild) begin
			gain = rbbm_pkg::DATA_W'($urandom);
			fb1  = rbbm_pkg::DATA_W'($urandom);
		end else begin
			// modest gain, feedback near a stable resonator
			gain = rbbm_pkg::DATA_W'(int'($urandom_range(200000)) - 100000);
			fb1  = rbbm_pkg::DATA_W'(int'($urandom_range(8000000)) - 4000000);
		end
		send(1'b1, rbbm_pkg::SAMPLE_W'($urandom), sel, gain, fb1);
	endtask

	task automatic reg_write(input logic idx, input logic [rbbm_pkg::DATA_W-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {8'h00, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic drain();
		audio.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		// a trailing load leaves no reading to wait for; give the band sequence time
		repeat (400) @(posedge clk);
	endtask

	task automatic random_run(input int n);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(19))
				0:       load_band(rbbm_pkg::SEL_W'($urandom), 1'b1);
				1, 2:    load_band(rbbm_pkg::SEL_W'($urandom), 1'b0);
				3:       send(1'b0, ($urandom_range(1) ? 16'sh7FFF : 16'sh8000),
					rbbm_pkg::SEL_W'($urandom), rbbm_pkg::DATA_W'($urandom),
					rbbm_pkg::DATA_W'($urandom));
				default: send(1'b0, rbbm_pkg::SAMPLE_W'($urandom), rbbm_pkg::SEL_W'($urandom),
					rbbm_pkg::DATA_W'($urandom), rbbm_pkg::DATA_W'($urandom));
			endcase
		end
	endtask

	initial begin
		arst_n        <= 1'b0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		audio.valid   <= 1'b0;
		audio.action  <= 1'b0;
		audio.sample  <= '0;
		audio.band_select    <= '0;
		audio.input_gain     <= '0;
		audio.first_feedback <= '0;
		send_idle_pct = 21;
		recv_idle_pct = 80;
		hold_req      = 0;
		samples_sent  = 0;
		loads_sent    = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every band gets coefficients before the first sample
		reg_write(rbbm_pkg::REG_DECAY, rbbm_pkg::DECAY_RST);
		reg_write(rbbm_pkg::REG_FB2, rbbm_pkg::FB2_RST);
		for (int b = 0; b < rbbm_pkg::NUM_BANDS; b++)
			load_band(rbbm_pkg::SEL_W'(b), 1'b0);
		send(1'b1, 16'sh0000, 5'd0, 24'sh7FFFFF, 24'sh7FFFFF);
		send(1'b1, 16'sh0000, 5'd31, 24'sh800000, 24'sh800000);
		send(1'b0, 16'sh7FFF, '0, '0, '0);
		send(1'b0, 16'sh8000, '0, '0, '0);
		send(1'b0, 16'sh0000, '0, '0, '0);
		send(1'b0, 16'sh0001, '0, '0, '0);
		send(1'b0, 16'shFFFF, '0, '0, '0);
		send(1'b1, 16'sh0000, 5'd0, 24'sh010000, 24'sh3C0000);
		send(1'b1, 16'sh0000, 5'd31, 24'sh010000, 24'sh3C0000);
		for (int i = 0; i < 6; i++)
			send(1'b0, 16'sh0000, '0, '0, '0);
		drain();

		reg_write(rbbm_pkg::REG_DECAY, 24'hFFFFFF);
		reg_write(rbbm_pkg::REG_FB2, 24'h800000);
		random_run(103);
		drain();

		send_idle_pct = 80;
		recv_idle_pct = 21;
		reg_write(rbbm_pkg::REG_DECAY, 24'h000000);
		reg_write(rbbm_pkg::REG_FB2, 24'h7FFFFF);
		random_run(103);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		reg_write(rbbm_pkg::REG_DECAY, rbbm_pkg::DATA_W'($urandom));
		reg_write(rbbm_pkg::REG_FB2, 24'h000000);
		hold_req = 1;
		random_run(103);
		drain();

		reg_write(rbbm_pkg::REG_DECAY, rbbm_pkg::DECAY_RST);
		reg_write(rbbm_pkg::REG_FB2, rbbm_pkg::DATA_W'($urandom));
		random_run(103);
		drain();

		$display("Run covered %0d samples and %0d coefficient loads, %0d band readings,",
			samples_sent, loads_sent, readings);
		$display("under five register settings with both sides stalling and one long hold.");
		if (errors == 0)
			$display("** resonator_bank_band_meter: PASSED **");
		else
			$display("** resonator_bank_band_meter: FAILED **");
		$finish;
	end

endmodule
